[sv/fifo_queue_with_search_delete_core_defines.svh]
// Assertion macros shared by the search-and-delete queue RTL.
`ifndef FIFO_QUEUE_WITH_SEARCH_DELETE_CORE_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_DELETE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define FQSD_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define FQSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FQSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FQSD_ASSERT(label, clk, rst_n, prop)
`define FQSD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FQSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[sv/fqsd_pkg.sv]
// Types and constants of the search-and-delete queue.
`timescale 1ns / 1ps

package fqsd_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int COUNT_W    = $clog2(DEPTH + 1);
	localparam int OCC_W      = 5;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int S_TDATA_W  = ((DATA_WIDTH + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((DATA_WIDTH + OCC_W + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_ENQUEUE = 2'd0,
		OP_DEQUEUE = 2'd1,
		OP_EXISTS  = 2'd2,
		OP_DELETE  = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic                  enq;
		logic                  deq;
		logic                  del;
		logic [DATA_WIDTH-1:0] key;
	} cmd_t;

endpackage

[sv/fqsd_cell.sv]
// One queue cell: holds a word, compares it with the key and shifts toward the head.
`timescale 1ns / 1ps

module fqsd_cell (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fqsd_pkg::cmd_t                  cmd,
	input  logic                            prev_valid,
	input  logic [fqsd_pkg::DATA_WIDTH-1:0] next_data,
	input  logic                            next_valid,
	input  logic                            match_in,
	input  logic [fqsd_pkg::DATA_WIDTH-1:0] take_in,
	output logic                            match_out,
	output logic                            first_hit,
	output logic [fqsd_pkg::DATA_WIDTH-1:0] take_out,
	output logic [fqsd_pkg::DATA_WIDTH-1:0] data,
	output logic                            valid
);

	logic [fqsd_pkg::DATA_WIDTH-1:0] data_q;
	logic                            valid_q;
	logic                            hit;
	logic                            shift;
	logic                            fill;

	assign hit       = valid_q && (data_q == cmd.key);
	assign match_out = match_in | hit;
	assign first_hit = hit & ~match_in;
	assign take_out  = first_hit ? data_q : take_in;
	assign shift     = cmd.deq | (cmd.del & match_out);
	assign fill      = cmd.enq & ~valid_q & prev_valid;
	assign data      = data_q;
	assign valid     = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
		end else if (fill) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= next_data;
		end else if (fill) begin
			data_q <= cmd.key;
		end
	end

endmodule

[sv/fifo_queue_with_search_delete_core.sv]
// Top level: a row of queue cells with count, result selection and output register.
`timescale 1ns / 1ps
`include "fifo_queue_with_search_delete_core_defines.svh"

// Bounded FIFO of DEPTH words that also answers "is this key held" and removes the oldest
// entry equal to a key while keeping order. Every request returns exactly one response
// with status and the occupancy after the request. Throughput is one request per clock
// while responses are taken: all cells compare against the key and shift toward the head
// in the same cycle, and the response is registered in the output register in the cycle
// after acceptance. While a response waits for m_tready, s_tready is low; the next request
// enters in the cycle that the waiting response is taken.

module fifo_queue_with_search_delete_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [fqsd_pkg::S_TDATA_W-1:0]   s_tdata,  // value
	input  logic [fqsd_pkg::OP_W-1:0]        s_tuser,  // operation
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [fqsd_pkg::M_TDATA_W-1:0]   m_tdata,  // result_value, occupancy
	output logic [fqsd_pkg::STATUS_W-1:0]    m_tuser   // status
);

	localparam int DW = fqsd_pkg::DATA_WIDTH;
	localparam int N  = fqsd_pkg::DEPTH;

	fqsd_pkg::op_t                 op;
	fqsd_pkg::cmd_t                cmd;
	logic                          acc;
	logic                          full;
	logic                          empty;
	logic                          found;
	logic [fqsd_pkg::COUNT_W-1:0]  count_q;
	logic [fqsd_pkg::COUNT_W-1:0]  count_next;
	logic [N:0]                    match_chain;
	logic [N-1:0]                  cell_valid;
	logic [N-1:0]                  cell_first;
	logic [DW-1:0]                 cell_data [N];
	logic [DW-1:0]                 take_chain [N+1];
	fqsd_pkg::status_t             status;
	logic [DW-1:0]                 result;
	logic                          out_valid_q;
	logic [DW-1:0]                 out_value_q;
	fqsd_pkg::status_t             out_status_q;
	logic [fqsd_pkg::OCC_W-1:0]    out_occ_q;

	assign op       = fqsd_pkg::op_t'(s_tuser);
	assign s_tready = ~out_valid_q | m_tready;
	assign acc      = s_tvalid & s_tready;
	assign full     = (count_q == fqsd_pkg::COUNT_W'(N));
	assign empty    = (count_q == '0);

	assign cmd.enq = acc && (op == fqsd_pkg::OP_ENQUEUE);
	assign cmd.deq = acc && (op == fqsd_pkg::OP_DEQUEUE);
	assign cmd.del = acc && (op == fqsd_pkg::OP_DELETE);
	assign cmd.key = s_tdata[DW-1:0];

	assign match_chain[0] = 1'b0;
	assign take_chain[0]  = '0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		logic          prev_v;
		logic          next_v;
		logic [DW-1:0] next_d;

		if (i == 0) begin : g_head
			assign prev_v = 1'b1;
		end else begin : g_body
			assign prev_v = cell_valid[i-1];
		end

		if (i == N - 1) begin : g_tail
			assign next_v = 1'b0;
			assign next_d = '0;
		end else begin : g_link
			assign next_v = cell_valid[i+1];
			assign next_d = cell_data[i+1];
		end

		fqsd_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.prev_valid (prev_v),
			.next_data  (next_d),
			.next_valid (next_v),
			.match_in   (match_chain[i]),
			.take_in    (take_chain[i]),
			.match_out  (match_chain[i+1]),
			.first_hit  (cell_first[i]),
			.take_out   (take_chain[i+1]),
			.data       (cell_data[i]),
			.valid      (cell_valid[i])
		);
	end

	assign found = match_chain[N];

	always_comb begin
		status     = fqsd_pkg::ST_OK;
		result     = '0;
		count_next = count_q;
		case (op)
			fqsd_pkg::OP_ENQUEUE: begin
				if (full) begin
					status = fqsd_pkg::ST_FULL;
				end else begin
					count_next = count_q + 1'b1;
				end
			end
			fqsd_pkg::OP_DEQUEUE: begin
				if (empty) begin
					status = fqsd_pkg::ST_EMPTY;
				end else begin
					result     = cell_data[0];
					count_next = count_q - 1'b1;
				end
			end
			fqsd_pkg::OP_EXISTS: begin
				status = found ? fqsd_pkg::ST_OK : fqsd_pkg::ST_NOT_FOUND;
			end
			fqsd_pkg::OP_DELETE: begin
				if (found) begin
					result     = take_chain[N];
					count_next = count_q - 1'b1;
				end else begin
					status = fqsd_pkg::ST_NOT_FOUND;
				end
			end
			default: begin
				status = fqsd_pkg::ST_NOT_FOUND;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			out_value_q  <= result;
			out_status_q <= status;
			out_occ_q    <= fqsd_pkg::OCC_W'(count_next);
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(fqsd_pkg::M_TDATA_W - DW - fqsd_pkg::OCC_W){1'b0}},
			out_occ_q, out_value_q};

	`FQSD_ASSERT(a_count_bound, clk, arst_n, count_q <= fqsd_pkg::COUNT_W'(N))
	`FQSD_ASSERT(a_valid_matches_count, clk, arst_n, $countones(cell_valid) == count_q)
	`FQSD_ASSERT(a_single_first_hit, clk, arst_n, $onehot0(cell_first))
	`FQSD_ASSERT_NEXT(a_enqueue_grows, clk, arst_n, cmd.enq && !full,
		count_q == $past(count_q) + 1'b1)
	`FQSD_ASSERT_NEXT(a_response_follows, clk, arst_n, acc, m_tvalid)

endmodule

[tb/fifo_queue_with_search_delete_core_tb.sv]
// Testbench for the search-and-delete queue: directed corners, fill/drain and random traffic.
`timescale 1ns / 1ps

module fifo_queue_with_search_delete_core_tb;

	localparam int DW            = fqsd_pkg::DATA_WIDTH;
	localparam int IDLE_PCT      = 28;
	localparam int WATCHDOG_MAX  = 2000;
	localparam int SETTLE_CYCLES = 8;
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		logic [DW-1:0]              word;
		fqsd_pkg::status_t          status;
		logic [fqsd_pkg::OCC_W-1:0] occupancy;
	} response_t;

	logic                              clk      = 1'b0;
	logic                              arst_n   = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [fqsd_pkg::S_TDATA_W-1:0]    s_tdata  = '0;  // value
	logic [fqsd_pkg::OP_W-1:0]         s_tuser  = fqsd_pkg::OP_ENQUEUE;  // operation
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [fqsd_pkg::M_TDATA_W-1:0]    m_tdata;  // result_value, occupancy
	logic [fqsd_pkg::STATUS_W-1:0]     m_tuser;  // status

	logic [DW-1:0]           model_words[$];
	response_t               awaited_responses[$];
	bit                      steady = 1'b0;
	int unsigned             op_count[4];
	int unsigned             full_hits, empty_hits, miss_hits, responses_seen;
	int unsigned             mismatches, quiet_cycles;

	fifo_queue_with_search_delete_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #6 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
	end

	task automatic predict_response(input fqsd_pkg::op_t op, input logic [DW-1:0] word,
			output response_t r);
		int hit;
		hit = -1;
		r.word = '0;
		r.status = fqsd_pkg::ST_OK;
		foreach (model_words[i])
			if (hit < 0 && model_words[i] == word)
				hit = i;
		case (op)
			fqsd_pkg::OP_ENQUEUE: begin
				if (model_words.size() >= fqsd_pkg::DEPTH) begin
					r.status = fqsd_pkg::ST_FULL;
					full_hits++;
				end else begin
					model_words.push_back(word);
				end
			end
			fqsd_pkg::OP_DEQUEUE: begin
				if (model_words.size() == 0) begin
					r.status = fqsd_pkg::ST_EMPTY;
					empty_hits++;
				end else begin
					r.word = model_words.pop_front();
				end
			end
			fqsd_pkg::OP_EXISTS: begin
				if (hit < 0) begin
					r.status = fqsd_pkg::ST_NOT_FOUND;
					miss_hits++;
				end
			end
			default: begin
				if (hit < 0) begin
					r.status = fqsd_pkg::ST_NOT_FOUND;
					miss_hits++;
				end else begin
					r.word = model_words[hit];
					model_words.delete(hit);
				end
			end
		endcase
		r.occupancy = fqsd_pkg::OCC_W'(model_words.size());
		op_count[op]++;
	endtask

	task automatic send_request(input fqsd_pkg::op_t op, input logic [DW-1:0] word);
		response_t r;
		@(negedge clk);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		do @(posedge clk); while (!s_tready);
		predict_response(op, word, r);
		awaited_responses.push_back(r);
	endtask

	function automatic logic [DW-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(99);
		if (model_words.size() != 0 && r < 45)
			return model_words[$urandom_range(model_words.size() - 1)];
		if (r < 60) begin
			case ($urandom_range(3))
				0: return '0;
				1: return '1;
				2: return 32'h8000_0000;
				default: return 32'h0000_0001;
			endcase
		end
		return $urandom();
	endfunction

	task automatic note_mismatch(input string what, input logic [DW-1:0] want,
			input logic [DW-1:0] got);
		mismatches++;
		if (mismatches <= REPORT_MAX)
			$display("%0t: mismatch in %s: expected %0h, got %0h", $time, what, want, got);
	endtask

	always @(posedge clk) begin : check_responses
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			responses_seen++;
			if (awaited_responses.size() == 0) begin
				note_mismatch("unrequested response", '0, m_tdata[DW-1:0]);
			end else begin
				want = awaited_responses.pop_front();
				if (m_tdata[DW-1:0] !== want.word)
					note_mismatch("result value", want.word, m_tdata[DW-1:0]);
				if (m_tdata[DW +: fqsd_pkg::OCC_W] !== want.occupancy)
					note_mismatch("occupancy", DW'(want.occupancy),
						DW'(m_tdata[DW +: fqsd_pkg::OCC_W]));
				if (m_tuser !== want.status)
					note_mismatch("status", DW'(want.status), DW'(m_tuser));
				if ((m_tdata >> (DW + fqsd_pkg::OCC_W)) !== '0)
					note_mismatch("tdata padding", '0,
						DW'(m_tdata >> (DW + fqsd_pkg::OCC_W)));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_MAX);
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic test_directed_corners();
		send_request(fqsd_pkg::OP_DEQUEUE, 32'hFFFF_FFFF);
		send_request(fqsd_pkg::OP_EXISTS, 32'h0000_0000);
		send_request(fqsd_pkg::OP_DELETE, 32'h0000_0000);
		send_request(fqsd_pkg::OP_ENQUEUE, 32'h0000_0000);
		send_request(fqsd_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
		send_request(fqsd_pkg::OP_ENQUEUE, 32'h5A5A_5A5A);
		send_request(fqsd_pkg::OP_ENQUEUE, 32'hFFFF_FFFF);
		send_request(fqsd_pkg::OP_EXISTS, 32'h0000_0000);
		send_request(fqsd_pkg::OP_EXISTS, 32'hFFFF_FFFF);
		send_request(fqsd_pkg::OP_EXISTS, 32'h1234_5678);
		send_request(fqsd_pkg::OP_DELETE, 32'hFFFF_FFFF);
		send_request(fqsd_pkg::OP_DELETE, 32'hFFFF_FFFF);
		send_request(fqsd_pkg::OP_DELETE, 32'h0000_0000);
		send_request(fqsd_pkg::OP_DELETE, 32'h0000_0099);
		send_request(fqsd_pkg::OP_DEQUEUE, 32'h0000_0000);
		send_request(fqsd_pkg::OP_DEQUEUE, 32'hA5A5_A5A5);
		send_request(fqsd_pkg::OP_EXISTS, 32'h5A5A_5A5A);
	endtask

	task automatic test_fill_and_drain();
		while (model_words.size() < fqsd_pkg::DEPTH)
			send_request(fqsd_pkg::OP_ENQUEUE, pick_word());
		repeat (2) send_request(fqsd_pkg::OP_ENQUEUE, $urandom());
		send_request(fqsd_pkg::OP_EXISTS, model_words[0]);
		send_request(fqsd_pkg::OP_EXISTS, model_words[fqsd_pkg::DEPTH-1]);
		send_request(fqsd_pkg::OP_DELETE, model_words[fqsd_pkg::DEPTH-1]);
		send_request(fqsd_pkg::OP_ENQUEUE, $urandom());
		send_request(fqsd_pkg::OP_DELETE, model_words[0]);
		send_request(fqsd_pkg::OP_DELETE, model_words[fqsd_pkg::DEPTH/2]);
		while (model_words.size() != 0)
			send_request(fqsd_pkg::OP_DEQUEUE, $urandom());
		send_request(fqsd_pkg::OP_DEQUEUE, $urandom());
	endtask

	task automatic run_mixed_traffic(input int count);
		int unsigned enq_pct;
		fqsd_pkg::op_t op;
		for (int i = 0; i < count; i++) begin
			enq_pct = ((i / 40) % 2 == 0) ? 55 : 20;
			if ($urandom_range(99) < enq_pct) begin
				op = fqsd_pkg::OP_ENQUEUE;
			end else begin
				case ($urandom_range(2))
					0: op = fqsd_pkg::OP_DEQUEUE;
					1: op = fqsd_pkg::OP_EXISTS;
					default: op = fqsd_pkg::OP_DELETE;
				endcase
			end
			send_request(op, (op == fqsd_pkg::OP_DEQUEUE) ? $urandom() : pick_word());
		end
	endtask

	task automatic test_random_traffic();
		run_mixed_traffic(600);
	endtask

	task automatic test_back_to_back();
		steady = 1'b1;
		run_mixed_traffic(120);
		steady = 1'b0;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		test_directed_corners();
		test_fill_and_drain();
		test_fill_and_drain();
		test_random_traffic();
		test_back_to_back();
		test_fill_and_drain();
		@(negedge clk) s_tvalid <= 1'b0;
		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("%0d responses checked: %0d enqueue, %0d dequeue, %0d exists, %0d delete",
			responses_seen, op_count[fqsd_pkg::OP_ENQUEUE], op_count[fqsd_pkg::OP_DEQUEUE],
			op_count[fqsd_pkg::OP_EXISTS], op_count[fqsd_pkg::OP_DELETE]);
		$display("full %0d, empty %0d, not found %0d, mismatches %0d",
			full_hits, empty_hits, miss_hits, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
